@@ design/kct_pkg.sv @@
// ----------------------------------------------------------------------------
// kct_pkg
// Shared types and constants for the keyed saturating counter table.
// ----------------------------------------------------------------------------
`default_nettype none

package kct_pkg;

  localparam int OP_W    = 2;
  localparam int KEY_W   = 64;
  localparam int VAL_W   = 32;
  localparam int COUNT_W = 31;
  localparam int STAT_W  = 2;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_SET    = 2'd1;
  localparam logic [OP_W-1:0] OP_GET    = 2'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_SAT  = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic load;
    logic update;
  } cmd_t;

endpackage

`default_nettype wire

@@ design/kct_ctrl.sv @@
// ----------------------------------------------------------------------------
// kct_ctrl
// Controller: sequences lookup and write-back, owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module kct_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  output kct_pkg::cmd_t    cmd
);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_UPDATE = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd.load      = 1'b0;
    cmd.update    = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (slot_free) begin
          cmd.update    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/kct_slots.sv @@
// ----------------------------------------------------------------------------
// kct_slots
// Datapath: register slots with parallel key compare, counter arithmetic,
// slot write-back and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kct_slots #(
  parameter int SLOTS = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire kct_pkg::cmd_t                        cmd,
  input  wire logic [kct_pkg::OP_W-1:0]             op,
  input  wire logic                                 kind,
  input  wire logic [kct_pkg::KEY_W-1:0]            key,
  input  wire logic signed [kct_pkg::VAL_W-1:0]     operand,
  output logic                                      res_hit,
  output logic [kct_pkg::COUNT_W-1:0]               res_value,
  output logic [kct_pkg::STAT_W-1:0]                res_status
);

  localparam int CW = kct_pkg::COUNT_W;
  localparam int VW = kct_pkg::VAL_W;

  logic [SLOTS-1:0]   slot_valid_r;
  logic               slot_kind_r  [SLOTS];
  logic [kct_pkg::KEY_W-1:0] slot_key_r [SLOTS];
  logic [CW-1:0]      slot_count_r [SLOTS];

  logic [SLOTS-1:0]   match_vec;
  logic [SLOTS-1:0]   free_vec;
  logic [SLOTS-1:0]   free_oh;
  logic [CW-1:0]      sel_count;

  logic [SLOTS-1:0]   match_r;
  logic [SLOTS-1:0]   free_oh_r;
  logic               hit_r;
  logic [CW-1:0]      count_r;
  logic [kct_pkg::OP_W-1:0] op_r;
  logic               kind_r;
  logic [kct_pkg::KEY_W-1:0] key_r;
  logic signed [VW-1:0] val_r;

  logic signed [VW:0] sum;
  logic               val_pos;
  logic               sum_sat;
  logic               sum_nonpos;
  logic               has_free;
  logic               wr_count;
  logic               clr_slot;
  logic               ins;
  logic [CW-1:0]      new_count;
  logic [CW-1:0]      rd_value;
  logic [kct_pkg::STAT_W-1:0] status;

  always_comb begin
    sel_count = '0;
    for (int i = 0; i < SLOTS; i++) begin
      match_vec[i] = slot_valid_r[i] && (slot_kind_r[i] == kind) && (slot_key_r[i] == key);
      if (match_vec[i]) begin
        sel_count = sel_count | slot_count_r[i];
      end
    end
  end

  assign free_vec = ~slot_valid_r;
  assign free_oh  = free_vec & (~free_vec + {{(SLOTS-1){1'b0}}, 1'b1});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      match_r   <= match_vec;
      free_oh_r <= free_oh;
      hit_r     <= |match_vec;
      count_r   <= sel_count;
      op_r      <= op;
      kind_r    <= kind;
      key_r     <= key;
      val_r     <= operand;
    end
  end

  assign sum        = $signed({2'b00, count_r}) + $signed({val_r[VW-1], val_r});
  assign val_pos    = !val_r[VW-1] && (val_r != '0);
  assign sum_sat    = val_pos && (sum > $signed({2'b00, kct_pkg::COUNT_MAX}));
  assign sum_nonpos = sum[VW] || (sum == '0);
  assign has_free   = |free_oh_r;

  always_comb begin
    wr_count  = 1'b0;
    clr_slot  = 1'b0;
    ins       = 1'b0;
    new_count = val_r[CW-1:0];
    rd_value  = '0;
    status    = kct_pkg::ST_OK;
    case (op_r)
      kct_pkg::OP_ADD: begin
        if (hit_r) begin
          if (sum_sat) begin
            wr_count  = 1'b1;
            new_count = kct_pkg::COUNT_MAX;
            status    = kct_pkg::ST_SAT;
          end else if (sum_nonpos) begin
            clr_slot = 1'b1;
          end else begin
            wr_count  = 1'b1;
            new_count = sum[CW-1:0];
          end
        end else if (val_pos) begin
          ins = has_free;
          if (!has_free) begin
            status = kct_pkg::ST_FULL;
          end
        end
      end
      kct_pkg::OP_SET: begin
        if (hit_r) begin
          if (val_pos) begin
            wr_count = 1'b1;
          end else begin
            clr_slot = 1'b1;
          end
        end else if (val_pos) begin
          ins = has_free;
          if (!has_free) begin
            status = kct_pkg::ST_FULL;
          end
        end
      end
      kct_pkg::OP_GET: begin
        if (hit_r) begin
          rd_value = count_r;
        end
      end
      kct_pkg::OP_REMOVE: begin
        clr_slot = hit_r;
      end
      default: begin
        status = kct_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (cmd.update) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (clr_slot && match_r[i]) begin
          slot_valid_r[i] <= 1'b0;
        end else if (ins && free_oh_r[i]) begin
          slot_valid_r[i] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (ins && free_oh_r[i]) begin
          slot_kind_r[i]  <= kind_r;
          slot_key_r[i]   <= key_r;
          slot_count_r[i] <= new_count;
        end else if (wr_count && match_r[i]) begin
          slot_count_r[i] <= new_count;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res_hit    <= hit_r;
      res_value  <= rd_value;
      res_status <= status;
    end
  end

endmodule

`default_nettype wire

@@ design/keyed_saturating_counter_table.sv @@
// ----------------------------------------------------------------------------
// keyed_saturating_counter_table
// Keyed table of positive 31-bit saturating counters with add, set, get and
// remove, stored in register slots searched by parallel key compare.
// ----------------------------------------------------------------------------
//  channel  ports                                            direction
//  in       in_valid/in_ready, in_opcode, in_key_kind,
//           in_key_id, in_operand_value                      in
//  out      out_valid/out_ready, out_hit, out_read_value,
//           out_status                                       out
//
//  For each transaction the key is compared against every slot in the
//  accept cycle, then the matched or lowest free slot is written back.
//  Reset clears all slot valid marks at once; no clearing pass is needed.
//  A finished result waits in the output register while the next transaction
//  is accepted; write-back stalls only while that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_saturating_counter_table #(
  parameter int TABLE_SLOTS = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [kct_pkg::OP_W-1:0]            in_opcode,
  input  wire logic                                in_key_kind,
  input  wire logic [kct_pkg::KEY_W-1:0]           in_key_id,
  input  wire logic signed [kct_pkg::VAL_W-1:0]    in_operand_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_hit,
  output logic [kct_pkg::COUNT_W-1:0]              out_read_value,
  output logic [kct_pkg::STAT_W-1:0]               out_status
);

  kct_pkg::cmd_t cmd;

  kct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  kct_slots #(
    .SLOTS (TABLE_SLOTS)
  ) u_slots (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .op         (in_opcode),
    .kind       (in_key_kind),
    .key        (in_key_id),
    .operand    (in_operand_value),
    .res_hit    (out_hit),
    .res_value  (out_read_value),
    .res_status (out_status)
  );

endmodule

`default_nettype wire

@@ bench/keyed_saturating_counter_table_tb.sv @@
// ----------------------------------------------------------------------------
// keyed_saturating_counter_table_tb
// Self-checking bench for the keyed counter table. A queue of table operations
// is driven with random gaps and output back-pressure. Every accepted
// transaction is run through a local model of the slot table, and each reply
// is checked in order against the predicted hit, count and status.
// ----------------------------------------------------------------------------

module keyed_saturating_counter_table_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS      = 64;
  localparam int POOL       = 80;
  localparam int ITEM_GOAL  = 1700;
  localparam int IDLE_LIMIT = 2000;
  localparam int MAX_SHOWN  = 10;

  typedef struct {
    logic [kct_pkg::OP_W-1:0]         op;
    logic                             kind;
    logic [kct_pkg::KEY_W-1:0]        id;
    logic signed [kct_pkg::VAL_W-1:0] val;
    int                               gap;
  } table_op_t;

  typedef struct packed {
    logic                        hit;
    logic [kct_pkg::COUNT_W-1:0] count;
    logic [kct_pkg::STAT_W-1:0]  status;
  } table_reply_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [kct_pkg::OP_W-1:0]          in_opcode = kct_pkg::OP_GET;
  logic                              in_key_kind = 1'b0;
  logic [kct_pkg::KEY_W-1:0]         in_key_id = '0;
  logic signed [kct_pkg::VAL_W-1:0]  in_operand_value = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic                              out_hit;
  logic [kct_pkg::COUNT_W-1:0]       out_read_value;
  logic [kct_pkg::STAT_W-1:0]        out_status;

  table_op_t    pending_ops[$];
  table_reply_t expected_replies[$];

  logic                        live  [SLOTS];
  logic                        owner [SLOTS];
  logic [kct_pkg::KEY_W-1:0]   ident [SLOTS];
  logic [kct_pkg::COUNT_W-1:0] tally [SLOTS];

  logic                      pool_kind [POOL];
  logic [kct_pkg::KEY_W-1:0] pool_id   [POOL];

  logic in_taken = 1'b0;
  int   in_wait = 0;
  int   out_wait = 0;
  int   out_cycle = 0;
  int   gap_style = 0;
  int   idle_cycles = 0;
  int   mismatches = 0;

  keyed_saturating_counter_table #(
    .TABLE_SLOTS(SLOTS)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_key_kind     (in_key_kind),
    .in_key_id       (in_key_id),
    .in_operand_value(in_operand_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_read_value  (out_read_value),
    .out_status      (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (gap_style == 0 || r < 60) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(4, 20);
  endfunction

  function automatic logic signed [kct_pkg::VAL_W-1:0] pick_amount();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return $urandom_range(1, 100);
    else if (r < 40) return 0 - int'($urandom_range(1, 100));
    else if (r < 50) return 0;
    else if (r < 65) return $urandom_range(32'h7000_0000, 32'h7FFF_FFFF);
    else if (r < 75) return 32'h8000_0000 | $urandom_range(0, 32'h0FFF_FFFF);
    else return $urandom;
  endfunction

  task automatic queue_op(input logic [kct_pkg::OP_W-1:0] op, input logic kind,
                          input logic [kct_pkg::KEY_W-1:0] id,
                          input logic signed [kct_pkg::VAL_W-1:0] val);
    table_op_t t;
    t.op   = op;
    t.kind = kind;
    t.id   = id;
    t.val  = val;
    t.gap  = pick_gap();
    pending_ops.insert(pending_ops.size(), t);
  endtask

  function automatic logic [kct_pkg::STAT_W-1:0] claim_slot(
      input int free_idx, input logic kind,
      input logic [kct_pkg::KEY_W-1:0] id,
      input logic signed [kct_pkg::VAL_W-1:0] val);
    if (free_idx < 0) return kct_pkg::ST_FULL;
    live[free_idx]  = 1'b1;
    owner[free_idx] = kind;
    ident[free_idx] = id;
    tally[free_idx] = val[kct_pkg::COUNT_W-1:0];
    return kct_pkg::ST_OK;
  endfunction

  function automatic table_reply_t apply_table_op(
      input logic [kct_pkg::OP_W-1:0] op, input logic kind,
      input logic [kct_pkg::KEY_W-1:0] id,
      input logic signed [kct_pkg::VAL_W-1:0] val);
    int           hit_idx;
    int           free_idx;
    longint       sum;
    table_reply_t r;
    hit_idx  = -1;
    free_idx = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit_idx < 0 && live[i] && owner[i] == kind && ident[i] == id) hit_idx = i;
      if (free_idx < 0 && !live[i]) free_idx = i;
    end
    r.hit    = (hit_idx >= 0);
    r.count  = '0;
    r.status = kct_pkg::ST_OK;
    case (op)
      kct_pkg::OP_ADD: begin
        if (hit_idx >= 0) begin
          sum = longint'(tally[hit_idx]) + longint'(val);
          if (val > 0 && sum > 64'sd2147483647) begin
            tally[hit_idx] = kct_pkg::COUNT_MAX;
            r.status = kct_pkg::ST_SAT;
          end else if (sum <= 0) begin
            live[hit_idx] = 1'b0;
          end else begin
            tally[hit_idx] = sum[kct_pkg::COUNT_W-1:0];
          end
        end else if (val > 0) begin
          r.status = claim_slot(free_idx, kind, id, val);
        end
      end
      kct_pkg::OP_SET: begin
        if (hit_idx >= 0) begin
          if (val > 0) tally[hit_idx] = val[kct_pkg::COUNT_W-1:0];
          else live[hit_idx] = 1'b0;
        end else if (val > 0) begin
          r.status = claim_slot(free_idx, kind, id, val);
        end
      end
      kct_pkg::OP_GET: begin
        if (hit_idx >= 0) r.count = tally[hit_idx];
      end
      default: begin
        if (hit_idx >= 0) live[hit_idx] = 1'b0;
      end
    endcase
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    table_op_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_wait > 0) begin
        in_wait  <= in_wait - 1;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        nxt = pending_ops.pop_front();
        in_opcode        <= nxt.op;
        in_key_kind      <= nxt.kind;
        in_key_id        <= nxt.id;
        in_operand_value <= nxt.val;
        in_valid         <= 1'b1;
        in_wait          <= nxt.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure, with calm stretches
  always @(negedge clk) begin
    int g;
    out_cycle <= out_cycle + 1;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_wait > 0) begin
      out_wait  <= out_wait - 1;
      out_ready <= 1'b0;
    end else if (((out_cycle / 256) % 4) == 0) begin
      out_ready <= 1'b1;
    end else begin
      g = $urandom_range(0, 99);
      if (g < 60) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        out_wait  <= (g < 90) ? $urandom_range(0, 2) : $urandom_range(3, 19);
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    table_reply_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("unexpected reply: hit %0d count %0d status %0d",
                     out_hit, out_read_value, out_status);
        end else begin
          want = expected_replies.pop_front();
          if (out_hit !== want.hit || out_read_value !== want.count ||
              out_status !== want.status) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("reply mismatch: hit %0d/%0d count %0d/%0d status %0d/%0d",
                       want.hit, out_hit, want.count, out_read_value,
                       want.status, out_status);
          end
        end
      end
      if (in_valid && in_ready)
        expected_replies.insert(expected_replies.size(),
                                apply_table_op(in_opcode, in_key_kind, in_key_id,
                                               in_operand_value));
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("keyed_saturating_counter_table_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    int                        round;
    int unsigned               r;
    int                        k;
    logic [kct_pkg::KEY_W-1:0] ones;
    logic [kct_pkg::KEY_W-1:0] alt_a;
    logic [kct_pkg::KEY_W-1:0] alt_b;

    ones  = '1;
    alt_a = 64'h5555_5555_5555_5555;
    alt_b = 64'hAAAA_AAAA_AAAA_AAAA;
    for (int i = 0; i < SLOTS; i++) begin
      live[i]  = 1'b0;
      owner[i] = 1'b0;
      ident[i] = '0;
      tally[i] = '0;
    end

    // directed
    gap_style = 1;
    queue_op(kct_pkg::OP_GET,    1'b0, '0,    $urandom);
    queue_op(kct_pkg::OP_REMOVE, 1'b1, ones,  $urandom);
    queue_op(kct_pkg::OP_ADD,    1'b0, '0,    0);
    queue_op(kct_pkg::OP_SET,    1'b0, '0,    32'sh8000_0000);
    queue_op(kct_pkg::OP_ADD,    1'b0, '0,    1);
    queue_op(kct_pkg::OP_GET,    1'b0, '0,    $urandom);
    queue_op(kct_pkg::OP_GET,    1'b1, '0,    $urandom);
    queue_op(kct_pkg::OP_ADD,    1'b0, '0,    32'sh7FFF_FFFF);
    queue_op(kct_pkg::OP_GET,    1'b0, '0,    $urandom);
    queue_op(kct_pkg::OP_ADD,    1'b0, '0,    -1);
    queue_op(kct_pkg::OP_ADD,    1'b0, '0,    32'sh8000_0000);
    queue_op(kct_pkg::OP_GET,    1'b0, '0,    $urandom);
    queue_op(kct_pkg::OP_SET,    1'b1, ones,  32'sh7FFF_FFFF);
    queue_op(kct_pkg::OP_SET,    1'b1, ones,  5);
    queue_op(kct_pkg::OP_ADD,    1'b1, ones,  -5);
    queue_op(kct_pkg::OP_SET,    1'b1, ones,  7);
    queue_op(kct_pkg::OP_SET,    1'b1, ones,  0);
    queue_op(kct_pkg::OP_SET,    1'b1, ones,  3);
    queue_op(kct_pkg::OP_SET,    1'b1, ones,  -1);
    queue_op(kct_pkg::OP_ADD,    1'b0, alt_a, 10);
    queue_op(kct_pkg::OP_ADD,    1'b1, alt_b, 20);
    queue_op(kct_pkg::OP_REMOVE, 1'b0, alt_a, $urandom);
    queue_op(kct_pkg::OP_ADD,    1'b0, 64'd123, 40);
    queue_op(kct_pkg::OP_GET,    1'b0, 64'd123, $urandom);
    queue_op(kct_pkg::OP_REMOVE, 1'b1, alt_b, $urandom);

    // key pool: pairs share an id and differ in kind
    for (int i = 0; i < POOL; i += 2) begin
      pool_id[i]       = {$urandom, $urandom};
      pool_id[i+1]     = pool_id[i];
      pool_kind[i]     = 1'b0;
      pool_kind[i+1]   = 1'b1;
    end
    pool_id[0] = '0;
    pool_id[1] = '0;
    pool_id[2] = ones;
    pool_id[3] = ones;

    // fill past capacity, churn, then drain
    round = 0;
    while (pending_ops.size() < ITEM_GOAL) begin
      gap_style = ($urandom_range(0, 2) == 0) ? 0 : 1;
      case (round % 4)
        0: begin
          for (int i = 0; i < POOL; i++)
            queue_op($urandom_range(0, 1) ? kct_pkg::OP_ADD : kct_pkg::OP_SET,
                     pool_kind[i], pool_id[i], $urandom_range(1, 1000));
        end
        3: begin
          for (int i = 0; i < POOL; i++)
            queue_op(kct_pkg::OP_REMOVE, pool_kind[i], pool_id[i], $urandom);
        end
        default: begin
          for (int i = 0; i < 150; i++) begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, POOL - 1);
            if ($urandom_range(0, 9) == 0)
              queue_op(r < 35 ? kct_pkg::OP_ADD : r < 55 ? kct_pkg::OP_SET :
                       r < 80 ? kct_pkg::OP_GET : kct_pkg::OP_REMOVE,
                       1'($urandom_range(0, 1)), {$urandom, $urandom}, pick_amount());
            else
              queue_op(r < 35 ? kct_pkg::OP_ADD : r < 55 ? kct_pkg::OP_SET :
                       r < 80 ? kct_pkg::OP_GET : kct_pkg::OP_REMOVE,
                       pool_kind[k], pool_id[k], pick_amount());
          end
        end
      endcase
      round++;
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() > 0 || in_valid || expected_replies.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    mismatches += expected_replies.size();
    if (mismatches == 0) begin
      $display("keyed_saturating_counter_table_tb: clean");
    end else begin
      $display("keyed_saturating_counter_table_tb: errors");
    end
    $finish;
  end

endmodule
